// ----- hw/rtl/hrl_pkg.sv -----
// Shared types and constants for the hex record loader parser.
package hrl_pkg;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  localparam int CHAR_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH  = 2;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       nl;
    logic [5:0] digit;
  } char_beat_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] record_total;
  } result_t;

  localparam int CHAR_BEAT_W = $bits(char_beat_t);
  localparam int RESULT_W    = $bits(result_t);

endpackage

// ----- hw/rtl/hrl_queue.sv -----
// Small synchronous FIFO used for the character and result queues of the parser.
module hrl_queue
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
  )
  (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
  );

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/hrl_front.sv -----
// Input side: accepts characters and classifies them into newline and digit value.
module hrl_front
  import hrl_pkg::*;
  (
    input  logic       in_push,
    input  logic [7:0] in_char_in,
    output logic       in_full,
    input  logic       q_full,
    output logic       q_push,
    output char_beat_t q_beat
  );

  logic [5:0] digit;

  always_comb begin
    if (in_char_in >= "0" && in_char_in <= "9") begin
      digit = 6'(in_char_in - 8'h30);
    end else if (in_char_in >= "A" && in_char_in <= "Z") begin
      digit = 6'(in_char_in - 8'h37);
    end else if (in_char_in >= "a" && in_char_in <= "z") begin
      digit = 6'(in_char_in - 8'h57);
    end else begin
      digit = 6'd0;
    end
  end

  assign in_full      = q_full;
  assign q_push       = in_push;
  assign q_beat.nl    = (in_char_in == NEWLINE_CHAR);
  assign q_beat.digit = digit;

endmodule

// ----- hw/rtl/hrl_back.sv -----
// Record parser: walks each line's count, offset, data and total fields.
module hrl_back
  import hrl_pkg::*;
  #(
    parameter int ADDR_BITS = 24
  )
  (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] board_base,
    input  logic        q_empty,
    input  char_beat_t  q_beat,
    output logic        q_pop,
    input  logic        o_full,
    output logic        o_push,
    output result_t     o_result
  );

  localparam logic [2:0] PH_LINE_START = 3'd0;
  localparam logic [2:0] PH_COUNT      = 3'd1;
  localparam logic [2:0] PH_OFFSET     = 3'd2;
  localparam logic [2:0] PH_DATA       = 3'd3;
  localparam logic [2:0] PH_TOTAL      = 3'd4;
  localparam logic [2:0] PH_TRAIL      = 3'd5;

  localparam int SUM_W = (ADDR_BITS > 24) ? ADDR_BITS : 24;

  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           digit_index_r, digit_index_nxt;
  logic [15:0]          field_accum_r, field_accum_nxt;
  logic [7:0]           bytes_left_r, bytes_left_nxt;
  logic [ADDR_BITS-1:0] next_address_r, next_address_nxt;
  logic                 finished_r, finished_nxt;

  logic [1:0]           di_take;
  logic [15:0]          acc_take;
  logic [7:0]           bytes_dec;
  logic [SUM_W-1:0]     addr_ext;
  logic [SUM_W-1:0]     base_sum;

  assign q_pop     = !q_empty && !o_full;
  assign di_take   = digit_index_r + 2'd1;
  assign bytes_dec = bytes_left_r - 8'd1;
  assign addr_ext  = SUM_W'(next_address_r);
  assign base_sum  = SUM_W'(board_base) + SUM_W'(acc_take);

  // Even digit positions open a new byte, odd ones add the low nibble.
  always_comb begin
    if (!digit_index_r[0]) begin
      acc_take = {field_accum_r[7:0], q_beat.digit[3:0], 4'b0000};
    end else begin
      acc_take = {field_accum_r[15:8], field_accum_r[7:0] + {2'b00, q_beat.digit}};
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    digit_index_nxt  = digit_index_r;
    field_accum_nxt  = field_accum_r;
    bytes_left_nxt   = bytes_left_r;
    next_address_nxt = next_address_r;
    finished_nxt     = finished_r;
    o_push           = 1'b0;
    o_result         = '0;
    if (q_pop && !finished_r) begin
      if (q_beat.nl) begin
        phase_nxt       = PH_LINE_START;
        digit_index_nxt = 2'd0;
        field_accum_nxt = 16'd0;
        bytes_left_nxt  = 8'd0;
      end else begin
        unique case (phase_r)
          PH_LINE_START: begin
            phase_nxt       = PH_COUNT;
            digit_index_nxt = 2'd0;
            field_accum_nxt = 16'd0;
          end
          PH_COUNT: begin
            digit_index_nxt = di_take;
            field_accum_nxt = acc_take;
            if (di_take == 2'd2) begin
              bytes_left_nxt  = acc_take[7:0];
              phase_nxt       = (acc_take[7:0] != 8'd0) ? PH_OFFSET : PH_TOTAL;
              digit_index_nxt = 2'd0;
              field_accum_nxt = 16'd0;
            end
          end
          PH_OFFSET: begin
            digit_index_nxt = di_take;
            field_accum_nxt = acc_take;
            if (di_take == 2'd0) begin
              next_address_nxt = ADDR_BITS'(base_sum);
              phase_nxt        = PH_DATA;
              field_accum_nxt  = 16'd0;
            end
          end
          PH_DATA: begin
            digit_index_nxt = di_take;
            field_accum_nxt = acc_take;
            if (di_take == 2'd2) begin
              o_push                 = 1'b1;
              o_result.kind          = KIND_DATA;
              o_result.write_address = addr_ext[23:0];
              o_result.write_data    = acc_take[7:0];
              next_address_nxt       = next_address_r + ADDR_BITS'(1);
              bytes_left_nxt         = bytes_dec;
              phase_nxt              = (bytes_dec != 8'd0) ? PH_DATA : PH_TRAIL;
              digit_index_nxt        = 2'd0;
              field_accum_nxt        = 16'd0;
            end
          end
          PH_TOTAL: begin
            digit_index_nxt = di_take;
            field_accum_nxt = acc_take;
            if (di_take == 2'd0) begin
              o_push                = 1'b1;
              o_result.kind         = KIND_TOTAL;
              o_result.record_total = acc_take;
              finished_nxt          = 1'b1;
              phase_nxt             = PH_TRAIL;
              field_accum_nxt       = 16'd0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LINE_START;
      digit_index_r  <= 2'd0;
      field_accum_r  <= 16'd0;
      bytes_left_r   <= 8'd0;
      next_address_r <= '0;
      finished_r     <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      digit_index_r  <= digit_index_nxt;
      field_accum_r  <= field_accum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      next_address_r <= next_address_nxt;
      finished_r     <= finished_nxt;
    end
  end

endmodule

// ----- hw/rtl/hex_record_loader_parser.sv -----
// Hex load record parser: text characters in, memory writes and the final total out.
//
// Input channel: one ASCII character per beat, accepted when in_push is high and
// in_full is low. Result channel: the oldest result sits on the out_ ports while
// out_empty is low and leaves on a clock edge with out_pop high.
// Each data byte gives a write beat (kind 0) at board base plus record offset plus
// byte index; an end record gives one total beat (kind 1), after which all further
// characters are taken and dropped.
// Configuration: cfg_we loads cfg_wdata into the board base register; it is used
// when a record's offset field completes.
// A character is registered in the character queue, and its result in the output queue.
// Throughput: one character per cycle while the output queue is not full, set by the
// parser's field update and the two-entry queues on either side of it.
// Reset clears the parser state, both queues and the board base to zero.
// When the receiver stalls, results collect in the output queue; once it is full
// the parser stops, the character queue fills and in_full rises.
module hex_record_loader_parser
  import hrl_pkg::*;
  #(
    parameter int ADDR_BITS = 24
  )
  (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        in_push,
    input  logic [7:0]  in_char_in,
    output logic        in_full,
    input  logic        out_pop,
    output logic        out_empty,
    output logic        out_kind,
    output logic [23:0] out_write_address,
    output logic [7:0]  out_write_data,
    output logic [15:0] out_record_total
  );

  logic [23:0]            cfg_board_base_r;
  logic                   cq_full;
  logic                   cq_push;
  char_beat_t             cq_wbeat;
  logic [CHAR_BEAT_W-1:0] cq_rdata;
  logic                   cq_empty;
  logic                   cq_pop;
  logic                   oq_full;
  logic                   oq_push;
  result_t                oq_wres;
  logic [RESULT_W-1:0]    oq_rdata;
  result_t                out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_board_base_r <= 24'd0;
    end else if (cfg_we) begin
      cfg_board_base_r <= cfg_wdata;
    end
  end

  hrl_front u_front (
    .in_push    (in_push),
    .in_char_in (in_char_in),
    .in_full    (in_full),
    .q_full     (cq_full),
    .q_push     (cq_push),
    .q_beat     (cq_wbeat)
  );

  hrl_queue #(.WIDTH(CHAR_BEAT_W), .DEPTH(CHAR_QUEUE_DEPTH)) u_char_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wbeat),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  hrl_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .board_base (cfg_board_base_r),
    .q_empty    (cq_empty),
    .q_beat     (char_beat_t'(cq_rdata)),
    .q_pop      (cq_pop),
    .o_full     (oq_full),
    .o_push     (oq_push),
    .o_result   (oq_wres)
  );

  hrl_queue #(.WIDTH(RESULT_W), .DEPTH(OUT_QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wres),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_res           = result_t'(oq_rdata);
  assign out_kind          = out_res.kind;
  assign out_write_address = out_res.write_address;
  assign out_write_data    = out_res.write_data;
  assign out_record_total  = out_res.record_total;

endmodule

// ----- hw/rtl/hrl_checker.sv -----
// Port-level checks for the hex record loader parser, bound to the top level.
module hrl_checker
  import hrl_pkg::*;
  (
    input logic        clk,
    input logic        rst_n,
    input logic        in_full,
    input logic        out_pop,
    input logic        out_empty,
    input logic        out_kind,
    input logic [23:0] out_write_address,
    input logic [7:0]  out_write_data,
    input logic [15:0] out_record_total
  );

  logic done_r;

  // Set once the total beat has been taken by the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (out_pop && !out_empty && out_kind == KIND_TOTAL) begin
      done_r <= 1'b1;
    end
  end

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_total_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_TOTAL) |->
      (out_write_address == 24'd0 && out_write_data == 8'd0))
    else $error("total beat carries write fields");

  a_data_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_DATA) |-> out_record_total == 16'd0)
    else $error("write beat carries a total");

  a_nothing_after_total : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> out_empty)
    else $error("result beat after the total");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_kind) && $stable(out_write_address)
       && $stable(out_write_data) && $stable(out_record_total)))
    else $error("stalled result beat changed");

endmodule

bind hex_record_loader_parser hrl_checker u_hrl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_pop           (out_pop),
  .out_empty         (out_empty),
  .out_kind          (out_kind),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_record_total  (out_record_total)
);

// ----- dv/tb_hex_record_loader_parser.sv -----
// Self-checking testbench for the hex record loader parser, with its own parse predictor.
module tb_hex_record_loader_parser;
  import hrl_pkg::*;

  typedef enum logic [2:0] {
    P_LINE_HEAD, P_COUNT, P_OFFSET, P_DATA, P_TOTAL, P_TAIL
  } parse_phase_e;

  typedef enum logic [1:0] {
    POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PATTERN
  } pop_style_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        in_push;
  logic [7:0]  in_char_in;
  logic        in_full;
  logic        out_pop;
  logic        out_empty;
  logic        out_kind;
  logic [23:0] out_write_address;
  logic [7:0]  out_write_data;
  logic [15:0] out_record_total;

  // Predictor state.
  parse_phase_e prs_phase;
  logic [1:0]   digit_pos;
  logic [15:0]  field_val;
  logic [7:0]   bytes_left;
  logic [23:0]  next_addr;
  logic         load_done;
  logic [23:0]  model_base;

  result_t pending_beats[$];
  int      fail_count;
  int      chars_sent;
  int      burst_left;
  int      rx_hold_req;
  bit      end_allowed;

  hex_record_loader_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_char_in        (in_char_in),
    .in_full           (in_full),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_kind          (out_kind),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_record_total  (out_record_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void begin_field(parse_phase_e ph);
    prs_phase = ph;
    digit_pos = 2'd0;
    field_val = 16'd0;
  endfunction

  // An even digit position starts a new byte and shifts the previous one up.
  function automatic void fold_digit(logic [5:0] d);
    if (!digit_pos[0]) field_val = {field_val[7:0], d[3:0], 4'h0};
    else field_val[7:0] = field_val[7:0] + {2'b00, d};
    digit_pos = digit_pos + 2'd1;
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    logic [5:0] d;
    result_t    r;
    if (load_done) return;
    if (ch == NEWLINE_CHAR) begin
      begin_field(P_LINE_HEAD);
      bytes_left = 8'd0;
      return;
    end
    if (ch >= "0" && ch <= "9") d = 6'(ch - "0");
    else if (ch >= "A" && ch <= "Z") d = 6'(ch - "A" + 8'd10);
    else if (ch >= "a" && ch <= "z") d = 6'(ch - "a" + 8'd10);
    else d = 6'd0;
    r = '0;
    case (prs_phase)
      P_LINE_HEAD: begin_field(P_COUNT);
      P_COUNT: begin
        fold_digit(d);
        if (digit_pos == 2'd2) begin
          bytes_left = field_val[7:0];
          if (bytes_left != 8'd0) begin_field(P_OFFSET);
          else begin_field(P_TOTAL);
        end
      end
      P_OFFSET: begin
        fold_digit(d);
        if (digit_pos == 2'd0) begin
          next_addr = model_base + {8'h00, field_val};
          begin_field(P_DATA);
        end
      end
      P_DATA: begin
        fold_digit(d);
        if (digit_pos == 2'd2) begin
          r.kind          = KIND_DATA;
          r.write_address = next_addr;
          r.write_data    = field_val[7:0];
          pending_beats.push_back(r);
          next_addr  = next_addr + 24'd1;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left != 8'd0) begin_field(P_DATA);
          else begin_field(P_TAIL);
        end
      end
      P_TOTAL: begin
        fold_digit(d);
        if (digit_pos == 2'd0) begin
          r.kind         = KIND_TOTAL;
          r.record_total = field_val;
          pending_beats.push_back(r);
          load_done = 1'b1;
          begin_field(P_TAIL);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    if ($urandom_range(0, 1) == 0) return 8'("A" + n - 4'd10);
    return 8'("a" + n - 4'd10);
  endfunction

  // Any character except newline.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == NEWLINE_CHAR);
    return c;
  endfunction

  // Offers one character and returns at the edge where it was taken.
  task automatic send_char(input logic [7:0] ch);
    logic taken;
    int   gap;
    // Keep loading alive until the final end record is meant to complete.
    if (!end_allowed && !load_done && prs_phase == P_TOTAL && digit_pos == 2'd3 &&
        ch != NEWLINE_CHAR)
      ch = NEWLINE_CHAR;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0, 1, 2: gap = 0;
        3, 4:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 30);
      endcase
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push    <= 1'b1;
    in_char_in <= ch;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_full === 1'b0);
      @(posedge clk);
    end
    chars_sent++;
    parse_char(ch);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i]);
  endtask

  // One data record line; cut_at >= 0 ends the line early with a newline.
  task automatic send_record(input logic [7:0] count, input logic [15:0] offset,
                             input int odd_pct, input int cut_at);
    logic [7:0] text[$];
    if ($urandom_range(0, 3) == 0) text.push_back(text_char());
    else text.push_back(":");
    text.push_back(hex_char(count[7:4]));
    text.push_back(hex_char(count[3:0]));
    for (int k = 3; k >= 0; k--) text.push_back(hex_char(offset[k*4 +: 4]));
    for (int i = 0; i < 2 * count; i++) begin
      if ($urandom_range(0, 99) < odd_pct) text.push_back(text_char());
      else text.push_back(hex_char(4'($urandom_range(0, 15))));
    end
    repeat ($urandom_range(0, 2)) text.push_back(text_char());
    if (cut_at >= 0) begin
      while (text.size() > cut_at) void'(text.pop_back());
    end
    text.push_back(NEWLINE_CHAR);
    send_text(text);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // Characters that give no result may still be in flight.
    repeat (6) @(posedge clk);
  endtask

  task automatic write_base(input logic [23:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_base = value;
  endtask

  task automatic test_directed();
    // Extreme characters as skipped head and as data digits, letters past F,
    // trailing text, an empty line, a cut record and a cut end record.
    send_text('{8'h00, "0", "2", "F", "F", "F", "F", "z", "Z", 8'hFF, 8'h00, "x",
                NEWLINE_CHAR});
    send_text('{NEWLINE_CHAR});
    send_text('{":", "9", NEWLINE_CHAR});
    send_text('{":", "0", "0", "1", "2", NEWLINE_CHAR});
  endtask

  task automatic test_board_base();
    logic [23:0] bases[4];
    bases = '{24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555};
    foreach (bases[i]) begin
      write_base(bases[i]);
      send_record(8'd2, 16'hFFFF, 0, -1);
      send_record(8'd1, 16'h0000, 0, -1);
    end
  endtask

  task automatic test_longest_record();
    // The address crosses the top of the 24-bit space partway through.
    write_base(24'hFF0000);
    send_record(8'hFF, 16'hFFA0, 5, -1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_hold_req = 250;
    send_record(8'd40, 16'($urandom_range(0, 65535)), 0, -1);
    wait_drained();
  endtask

  task automatic test_random_lines();
    logic [23:0] bases[4];
    logic [7:0]  count;
    logic [15:0] offset;
    logic [7:0]  text[$];
    int          phase_start;
    bases = '{24'($urandom), 24'hFFFFFF, 24'h000000, 24'($urandom)};
    foreach (bases[p]) begin
      write_base(bases[p]);
      phase_start = chars_sent;
      while (chars_sent - phase_start < 270) begin
        if ($urandom_range(0, 9) == 0) count = 8'($urandom_range(17, 48));
        else count = 8'($urandom_range(1, 16));
        if ($urandom_range(0, 7) == 0) offset = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        else offset = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 19))
          14, 15: send_record(count, offset, 10, $urandom_range(0, 2 * count + 6));
          16: send_char(NEWLINE_CHAR);
          17: begin
            repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(0, 255)));
            send_char(NEWLINE_CHAR);
          end
          18: begin
            text = '{":", "0", "0"};
            repeat ($urandom_range(0, 3)) text.push_back(hex_char(4'($urandom)));
            text.push_back(NEWLINE_CHAR);
            send_text(text);
          end
          19: send_record(count, offset, 30, -1);
          default: send_record(count, offset, 0, -1);
        endcase
      end
    end
  endtask

  task automatic test_end_record();
    logic [7:0] text[$];
    end_allowed = 1'b1;
    text = '{":", "0", "0"};
    repeat (4) begin
      if ($urandom_range(0, 4) == 0) text.push_back(text_char());
      else text.push_back(hex_char(4'($urandom)));
    end
    text.push_back("x");
    text.push_back(NEWLINE_CHAR);
    send_text(text);
    // Everything after the total is dropped, well-formed records included.
    send_record(8'd3, 16'h1234, 0, -1);
    repeat (20) send_char(8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input logic [23:0] expv,
                             input logic [23:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, expv, actv);
      fail_count++;
    end
  endtask

  // Outputs are stable at the falling edge; a beat seen here leaves at the next rise.
  always @(negedge clk) begin
    result_t exp_beat;
    if (rst_n === 1'b1 && out_pop === 1'b1 && out_empty === 1'b0) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        exp_beat = pending_beats.pop_front();
        check_field("kind", 24'(exp_beat.kind), 24'(out_kind));
        check_field("write_address", exp_beat.write_address, out_write_address);
        check_field("write_data", 24'(exp_beat.write_data), 24'(out_write_data));
        check_field("record_total", 24'(exp_beat.record_total), 24'(out_record_total));
      end
    end
  end

  // Receiver: changes its stall style now and then, and honors long hold-offs.
  initial begin
    int         hold_left = 0;
    int         style_left = 0;
    int         ticks = 0;
    pop_style_e style;
    style = POP_ALWAYS;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (style_left == 0) begin
        style      = pop_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      ticks++;
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (style)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_MOSTLY: out_pop <= ($urandom_range(0, 3) != 0);
          POP_RARELY: out_pop <= ($urandom_range(0, 3) == 0);
          default:    out_pop <= ((ticks % 7) < 3);
        endcase
      end
    end
  end

  initial begin
    fail_count  = 0;
    chars_sent  = 0;
    burst_left  = 0;
    rx_hold_req = 0;
    end_allowed = 1'b0;
    model_base  = 24'd0;
    bytes_left  = 8'd0;
    next_addr   = 24'd0;
    load_done   = 1'b0;
    begin_field(P_LINE_HEAD);
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 24'd0;
    in_push    <= 1'b0;
    in_char_in <= 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_board_base();
    test_longest_record();
    test_backpressure();
    test_random_lines();
    test_end_record();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
